/* hw/rtl/lcdw_pkg.sv */
// shared constants, types and lookup functions for the lcd line writer
package lcdw_pkg;

    localparam int COLUMNS = 20;
    localparam int ROWS    = 4;
    localparam int WAIT_W  = 18;
    localparam int COL_W   = $clog2(COLUMNS + 1);
    localparam int IDX_W   = 3;
    localparam int SRC_W   = 3;
    localparam int ADDR_W  = 4;

    // register indexes
    localparam logic [1:0] REG_POWER_UP  = 2'd0;
    localparam logic [1:0] REG_WAKE_GAP  = 2'd1;
    localparam logic [1:0] REG_NIBBLE    = 2'd2;
    localparam logic [1:0] REG_BYTE_GAP  = 2'd3;

    // reset values of the wait registers
    localparam logic [WAIT_W-1:0] RST_POWER_UP = 18'd132000;
    localparam logic [WAIT_W-1:0] RST_WAKE_GAP = 18'd10000;
    localparam logic [WAIT_W-1:0] RST_NIBBLE   = 18'd1000;
    localparam logic [WAIT_W-1:0] RST_BYTE_GAP = 18'd2000;

    // strobe source codes
    localparam logic [SRC_W-1:0] SRC_WAKE   = 3'd0;
    localparam logic [SRC_W-1:0] SRC_SETUP  = 3'd1;
    localparam logic [SRC_W-1:0] SRC_CURSOR = 3'd2;
    localparam logic [SRC_W-1:0] SRC_CHAR   = 3'd3;
    localparam logic [SRC_W-1:0] SRC_PAD    = 3'd4;

    // sequence positions
    localparam logic [IDX_W-1:0] WAKE_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] WAKE_FINAL = 3'd3;
    localparam logic [IDX_W-1:0] SETUP_FINAL = 3'd5;

    localparam logic [3:0] WAKE_NIB      = 4'h3;
    localparam logic [3:0] WAKE_LAST_NIB = 4'h2;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    typedef struct packed {
        logic [WAIT_W-1:0] power_up_wait_us;
        logic [WAIT_W-1:0] wake_gap_us;
        logic [WAIT_W-1:0] nibble_gap_us;
        logic [WAIT_W-1:0] byte_gap_us;
    } lcdw_cfg_t;

    typedef struct packed {
        logic             latch;
        logic             emit;
        logic [SRC_W-1:0] src;
        logic [IDX_W-1:0] idx;
        logic             hi;
        logic             last;
        logic             col_inc;
        logic             col_clear;
    } lcdw_cmd_t;

    typedef struct packed {
        logic kind;
        logic full;
        logic term;
        logic need_cursor;
        logic col_last;
        logic slot_free;
    } lcdw_stat_t;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] r;
        case (row)
            2'd0:    r = 8'h00;
            2'd1:    r = 8'h40;
            2'd2:    r = 8'h14;
            default: r = 8'h54;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] setup_cmd(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h10;
            3'd2:    c = 8'h0C;
            3'd3:    c = 8'h06;
            3'd4:    c = 8'h02;
            3'd5:    c = 8'h01;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/char_lcd_4bit_line_writer.sv */
// char lcd 4-bit line writer: turns init and character items into timed nibble strobes
// first strobe of an item passes through the decide state and a strobe state into the output register
// throughput: one strobe per cycle while m_tready is high, set by the sequencer fsm;
//   init 16 strobes, a character 2 or 4, a terminator up to 2 + 2*COLUMNS
// next item is taken the cycle after the item's last strobe is registered
// reset: synchronous active-low aresetn restores wait registers and clears line state
module char_lcd_4bit_line_writer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // line[1:0], char_code[9:2], zero pad
    input  logic                        s_tuser,   // kind
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // nibble[3:0], wait_before_us[21:4]
    output logic                        m_tuser,   // rs
    output logic                        m_tlast,   // last
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcdw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    lcdw_pkg::lcdw_cfg_t  cfg;
    lcdw_pkg::lcdw_cmd_t  cmd;
    lcdw_pkg::lcdw_stat_t stat;
    logic [3:0]                  out_nibble;
    logic [lcdw_pkg::WAIT_W-1:0] out_wait;

    lcdw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcdw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcdw_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_kind    (s_tuser),
        .in_line    (s_tdata[1:0]),
        .in_code    (s_tdata[9:2]),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_rs     (m_tuser),
        .out_nibble (out_nibble),
        .out_wait   (out_wait),
        .out_last   (m_tlast)
    );

    // pack result payload
    assign m_tdata = {2'b00, out_wait, out_nibble};

`ifndef SYNTH
    // a new strobe never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.slot_free)
        else $error("strobe issued while output register busy");

    // after a transfer in, the block is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // the last strobe of an item returns the sequencer to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> s_tready)
        else $error("sequencer not idle after last strobe");

    // last strobe is always a low nibble
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |-> !cmd.hi)
        else $error("last flag on a high nibble");
`endif

endmodule

/* hw/rtl/lcdw_regs.sv */
// apb wait-time configuration registers
module lcdw_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcdw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output lcdw_pkg::lcdw_cfg_t         cfg
);

    lcdw_pkg::lcdw_cfg_t cfg_reg;
    logic                wr_en;
    logic [lcdw_pkg::WAIT_W-1:0] wdata;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign wdata   = pwdata[lcdw_pkg::WAIT_W-1:0];
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_up_wait_us <= lcdw_pkg::RST_POWER_UP;
            cfg_reg.wake_gap_us      <= lcdw_pkg::RST_WAKE_GAP;
            cfg_reg.nibble_gap_us    <= lcdw_pkg::RST_NIBBLE;
            cfg_reg.byte_gap_us      <= lcdw_pkg::RST_BYTE_GAP;
        end else if (wr_en) begin
            case (reg_idx)
                lcdw_pkg::REG_POWER_UP: cfg_reg.power_up_wait_us <= wdata;
                lcdw_pkg::REG_WAKE_GAP: cfg_reg.wake_gap_us      <= wdata;
                lcdw_pkg::REG_NIBBLE:   cfg_reg.nibble_gap_us    <= wdata;
                lcdw_pkg::REG_BYTE_GAP: cfg_reg.byte_gap_us      <= wdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            lcdw_pkg::REG_POWER_UP: prdata = 32'(cfg_reg.power_up_wait_us);
            lcdw_pkg::REG_WAKE_GAP: prdata = 32'(cfg_reg.wake_gap_us);
            lcdw_pkg::REG_NIBBLE:   prdata = 32'(cfg_reg.nibble_gap_us);
            lcdw_pkg::REG_BYTE_GAP: prdata = 32'(cfg_reg.byte_gap_us);
            default:                prdata = 32'd0;
        endcase
    end

endmodule

/* hw/rtl/lcdw_ctrl.sv */
// strobe sequencer state machine
module lcdw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lcdw_pkg::lcdw_stat_t stat,
    output lcdw_pkg::lcdw_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_WAKE   = 3'd2;
    localparam logic [2:0] ST_SETUP  = 3'd3;
    localparam logic [2:0] ST_CURSOR = 3'd4;
    localparam logic [2:0] ST_CHAR   = 3'd5;
    localparam logic [2:0] ST_PAD    = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [lcdw_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       hi_reg, hi_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            hi_reg    <= 1'b1;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hi_reg    <= hi_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        hi_next       = hi_reg;
        cmd           = '0;
        cmd.idx       = idx_reg;
        cmd.hi        = hi_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                hi_next = 1'b1;
                if (!stat.kind) begin
                    idx_next   = lcdw_pkg::WAKE_FIRST;
                    state_next = ST_WAKE;
                end else if (stat.full) begin
                    // overlong line: drop, a terminator just closes the line
                    cmd.col_clear = stat.term;
                    state_next    = ST_IDLE;
                end else if (stat.need_cursor) begin
                    state_next = ST_CURSOR;
                end else begin
                    state_next = stat.term ? ST_PAD : ST_CHAR;
                end
            end
            ST_WAKE: begin
                cmd.src = lcdw_pkg::SRC_WAKE;
                if (stat.slot_free) begin
                    cmd.emit = 1'b1;
                    if (idx_reg == lcdw_pkg::WAKE_FINAL) begin
                        idx_next   = '0;
                        hi_next    = 1'b1;
                        state_next = ST_SETUP;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                cmd.src = lcdw_pkg::SRC_SETUP;
                if (stat.slot_free) begin
                    cmd.emit = 1'b1;
                    if (hi_reg) begin
                        hi_next = 1'b0;
                    end else begin
                        hi_next = 1'b1;
                        if (idx_reg == lcdw_pkg::SETUP_FINAL) begin
                            cmd.last      = 1'b1;
                            cmd.col_clear = 1'b1;
                            state_next    = ST_IDLE;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
            end
            ST_CURSOR: begin
                cmd.src = lcdw_pkg::SRC_CURSOR;
                if (stat.slot_free) begin
                    cmd.emit = 1'b1;
                    hi_next  = !hi_reg;
                    if (!hi_reg) begin
                        state_next = stat.term ? ST_PAD : ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                cmd.src = lcdw_pkg::SRC_CHAR;
                if (stat.slot_free) begin
                    cmd.emit = 1'b1;
                    hi_next  = !hi_reg;
                    if (!hi_reg) begin
                        cmd.last    = 1'b1;
                        cmd.col_inc = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                cmd.src = lcdw_pkg::SRC_PAD;
                if (stat.slot_free) begin
                    cmd.emit = 1'b1;
                    hi_next  = !hi_reg;
                    if (!hi_reg) begin
                        cmd.col_inc = 1'b1;
                        if (stat.col_last) begin
                            cmd.last      = 1'b1;
                            cmd.col_clear = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lcdw_dp.sv */
// item latch, line position and strobe output register
module lcdw_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_kind,
    input  logic [1:0]          in_line,
    input  logic [7:0]          in_code,
    input  lcdw_pkg::lcdw_cfg_t cfg,
    input  lcdw_pkg::lcdw_cmd_t cmd,
    output lcdw_pkg::lcdw_stat_t stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_rs,
    output logic [3:0]          out_nibble,
    output logic [lcdw_pkg::WAIT_W-1:0] out_wait,
    output logic                out_last
);

    logic                       kind_reg;
    logic [1:0]                 line_reg;
    logic [7:0]                 code_reg;
    logic [lcdw_pkg::COL_W-1:0] column_reg;
    logic                       full_reg;
    logic                       valid_reg;
    logic                       rs_reg;
    logic [3:0]                 nibble_reg;
    logic [lcdw_pkg::WAIT_W-1:0] wait_reg;
    logic                       last_reg;

    logic                       col_last;
    logic [7:0]                 byte_val;
    logic                       rs_val;
    logic [3:0]                 nib_val;
    logic [lcdw_pkg::WAIT_W-1:0] wait_val;

    assign col_last = (column_reg == lcdw_pkg::COL_W'(lcdw_pkg::COLUMNS - 1));

    // status toward the sequencer
    always_comb begin
        stat.kind        = kind_reg;
        stat.full        = full_reg;
        stat.term        = (code_reg == 8'd0);
        stat.need_cursor = (column_reg == '0) && !full_reg &&
                           (32'(line_reg) < lcdw_pkg::ROWS);
        stat.col_last    = col_last;
        stat.slot_free   = !valid_reg || out_ready;
    end

    // input item latch
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg <= in_kind;
            line_reg <= in_line;
            code_reg <= in_code;
        end
    end

    // line position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            full_reg   <= 1'b0;
        end else if (cmd.col_clear) begin
            column_reg <= '0;
            full_reg   <= 1'b0;
        end else if (cmd.col_inc) begin
            column_reg <= column_reg + 1'b1;
            if (col_last) begin
                full_reg <= 1'b1;
            end
        end
    end

    // strobe contents
    always_comb begin
        case (cmd.src)
            lcdw_pkg::SRC_SETUP:  byte_val = lcdw_pkg::setup_cmd(cmd.idx);
            lcdw_pkg::SRC_CURSOR: byte_val = lcdw_pkg::CMD_SET_DDRAM |
                                             lcdw_pkg::row_offset(line_reg);
            lcdw_pkg::SRC_CHAR:   byte_val = code_reg;
            default:              byte_val = 8'd0;
        endcase
        rs_val = (cmd.src == lcdw_pkg::SRC_CHAR) || (cmd.src == lcdw_pkg::SRC_PAD);
        if (cmd.src == lcdw_pkg::SRC_WAKE) begin
            nib_val  = (cmd.idx == lcdw_pkg::WAKE_FINAL) ? lcdw_pkg::WAKE_LAST_NIB
                                                         : lcdw_pkg::WAKE_NIB;
            wait_val = (cmd.idx == lcdw_pkg::WAKE_FIRST) ? cfg.power_up_wait_us
                                                         : cfg.wake_gap_us;
        end else begin
            nib_val  = cmd.hi ? byte_val[7:4] : byte_val[3:0];
            wait_val = cmd.hi ? cfg.byte_gap_us : cfg.nibble_gap_us;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            rs_reg     <= rs_val;
            nibble_reg <= nib_val;
            wait_reg   <= wait_val;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rs     = rs_reg;
    assign out_nibble = nibble_reg;
    assign out_wait   = wait_reg;
    assign out_last   = last_reg;

endmodule

/* bench/tb_char_lcd_4bit_line_writer.sv */
// self-checking testbench for the char lcd 4-bit line writer
`timescale 1ns / 1ps

module tb_char_lcd_4bit_line_writer;

    // item kinds carried on s_tuser
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    // register select levels
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // setup commands sent after the wake strobes
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_CURSOR_SHIFT = 8'h10;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [47:0] SETUP_SEQ = {CMD_CLEAR, CMD_HOME, CMD_ENTRY_MODE,
                                         CMD_DISPLAY_ON, CMD_CURSOR_SHIFT,
                                         CMD_FUNCTION_SET};
    localparam int SETUP_COUNT = 6;

    // ddram start address of each row, row 0 in the lowest byte
    localparam logic [31:0] ROW_STARTS = {8'h54, 8'h14, 8'h40, 8'h00};

    localparam logic [7:0] CODE_END  = 8'h00;
    localparam logic [lcdw_pkg::WAIT_W-1:0] WAIT_MAX = {lcdw_pkg::WAIT_W{1'b1}};

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;

    typedef struct packed {
        logic                        rs;
        logic [3:0]                  nibble;
        logic [lcdw_pkg::WAIT_W-1:0] wait_us;
        logic                        last;
    } strobe_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [15:0]                 s_tdata;   // line[1:0], char_code[9:2], zero pad
    logic                        s_tuser;   // kind
    logic                        m_tvalid;
    logic                        m_tready;
    logic [23:0]                 m_tdata;   // nibble[3:0], wait_before_us[21:4], zero pad
    logic                        m_tuser;   // rs
    logic                        m_tlast;   // last
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lcdw_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // predictor state
    strobe_t              strobe_q[$];
    lcdw_pkg::lcdw_cfg_t  wait_cfg;
    int                   line_col;
    bit                   line_is_full;

    int  mismatch_count;
    int  idle_cycles;
    bit  burst_mode;

    char_lcd_4bit_line_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int unsigned expv,
                                   input int unsigned actv);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %s: expected 0x%0h, got 0x%0h", what, expv, actv);
        end
    endtask

    // expected strobe builders
    function automatic void push_strobe(input logic rs, input logic [3:0] nib,
                                        input logic [lcdw_pkg::WAIT_W-1:0] wait_us);
        strobe_t s;
        s.rs      = rs;
        s.nibble  = nib;
        s.wait_us = wait_us;
        s.last    = 1'b0;
        strobe_q.push_back(s);
    endfunction

    function automatic void push_byte(input logic rs, input logic [7:0] b);
        push_strobe(rs, b[7:4], wait_cfg.byte_gap_us);
        push_strobe(rs, b[3:0], wait_cfg.nibble_gap_us);
    endfunction

    // work out the strobe run that one accepted item causes
    function automatic void predict_strobes(input logic kind, input logic [1:0] row,
                                            input logic [7:0] code);
        int first;
        first = strobe_q.size();
        if (kind == KIND_INIT) begin
            push_strobe(RS_CMD, lcdw_pkg::WAKE_NIB, wait_cfg.power_up_wait_us);
            push_strobe(RS_CMD, lcdw_pkg::WAKE_NIB, wait_cfg.wake_gap_us);
            push_strobe(RS_CMD, lcdw_pkg::WAKE_NIB, wait_cfg.wake_gap_us);
            push_strobe(RS_CMD, lcdw_pkg::WAKE_LAST_NIB, wait_cfg.wake_gap_us);
            for (int i = 0; i < SETUP_COUNT; i++) begin
                push_byte(RS_CMD, SETUP_SEQ[i*8 +: 8]);
            end
            line_col     = 0;
            line_is_full = 1'b0;
        end else if (!(line_is_full && code != CODE_END)) begin
            // cursor move on the first character of a line
            if (line_col == 0 && !line_is_full && row < lcdw_pkg::ROWS) begin
                push_byte(RS_CMD, lcdw_pkg::CMD_SET_DDRAM | ROW_STARTS[row*8 +: 8]);
            end
            if (code != CODE_END) begin
                push_byte(RS_DATA, code);
                line_col++;
                if (line_col >= lcdw_pkg::COLUMNS) line_is_full = 1'b1;
            end else begin
                // terminator pads the rest of the line
                while (line_col < lcdw_pkg::COLUMNS) begin
                    push_byte(RS_DATA, CODE_END);
                    line_col++;
                end
                line_col     = 0;
                line_is_full = 1'b0;
            end
        end
        if (strobe_q.size() > first) strobe_q[strobe_q.size() - 1].last = 1'b1;
    endfunction

    // one input transfer, with a random gap in front unless in burst mode
    task automatic send_item(input logic kind, input logic [1:0] row,
                             input logic [7:0] code);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, code, row};
        do @(posedge aclk); while (!s_tready);
        predict_strobes(kind, row, code);
    endtask

    // hold the sender until every expected strobe has come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (strobe_q.size() != 0) @(posedge aclk);
    endtask

    // one apb transfer: setup cycle then access cycle
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr) begin
            case (idx)
                lcdw_pkg::REG_POWER_UP:
                    wait_cfg.power_up_wait_us = wdata[lcdw_pkg::WAIT_W-1:0];
                lcdw_pkg::REG_WAKE_GAP:
                    wait_cfg.wake_gap_us      = wdata[lcdw_pkg::WAIT_W-1:0];
                lcdw_pkg::REG_NIBBLE:
                    wait_cfg.nibble_gap_us    = wdata[lcdw_pkg::WAIT_W-1:0];
                default:
                    wait_cfg.byte_gap_us      = wdata[lcdw_pkg::WAIT_W-1:0];
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // read all four wait registers back against the predictor copy
    task automatic check_registers();
        logic [31:0] rd;
        logic [lcdw_pkg::WAIT_W-1:0] expv;
        for (int i = 0; i < 4; i++) begin
            apb_access(1'b0, i[1:0], 32'h0, rd);
            case (i[1:0])
                lcdw_pkg::REG_POWER_UP: expv = wait_cfg.power_up_wait_us;
                lcdw_pkg::REG_WAKE_GAP: expv = wait_cfg.wake_gap_us;
                lcdw_pkg::REG_NIBBLE:   expv = wait_cfg.nibble_gap_us;
                default:                expv = wait_cfg.byte_gap_us;
            endcase
            if (rd[lcdw_pkg::WAIT_W-1:0] !== expv)
                report_mismatch("register readback", expv, rd);
        end
    endtask

    // reprogram every wait register once the block has gone quiet
    task automatic set_waits(input logic [31:0] pw, input logic [31:0] wk,
                             input logic [31:0] nb, input logic [31:0] bg);
        logic [31:0] rd;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_access(1'b1, lcdw_pkg::REG_POWER_UP, pw, rd);
        apb_access(1'b1, lcdw_pkg::REG_WAKE_GAP, wk, rd);
        apb_access(1'b1, lcdw_pkg::REG_NIBBLE, nb, rd);
        apb_access(1'b1, lcdw_pkg::REG_BYTE_GAP, bg, rd);
        check_registers();
    endtask

    // reset values, then the init sequence with them
    task automatic test_reset_init();
        check_registers();
        send_item(KIND_INIT, 2'd0, 8'h00);
    endtask

    // full line, extra characters dropped, terminator on a full line
    task automatic test_overlong_line();
        send_item(KIND_CHAR, 2'd0, 8'h01);
        for (int i = 1; i < lcdw_pkg::COLUMNS; i++) begin
            send_item(KIND_CHAR, 2'($urandom_range(3)), 8'($urandom_range(1, 255)));
        end
        send_item(KIND_CHAR, 2'd2, 8'hFF);
        send_item(KIND_CHAR, 2'd0, CODE_END);
    endtask

    // bare terminator pads a whole line, top code on another row
    task automatic test_row_starts();
        send_item(KIND_CHAR, 2'd3, CODE_END);
        send_item(KIND_CHAR, 2'd1, 8'hFF);
        send_item(KIND_CHAR, 2'd2, CODE_END);
    endtask

    // mostly well-formed lines with random content, some inits and noise
    task automatic test_random_lines(input int n_items, input bit pause_midway);
        int sent;
        int pick;
        int len;
        logic [1:0] row;
        sent = 0;
        while (sent < n_items) begin
            if (pause_midway && sent >= n_items / 2) begin
                wait_drain();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
                send_item(KIND_INIT, 2'($urandom_range(3)), 8'($urandom_range(255)));
                sent++;
            end else if (pick == 1) begin
                send_item(1'($urandom_range(1)), 2'($urandom_range(3)),
                          8'($urandom_range(255)));
                sent++;
            end else begin
                row = 2'($urandom_range(3));
                len = ($urandom_range(7) == 0) ? $urandom_range(18, 23)
                                               : $urandom_range(0, 6);
                for (int i = 0; i < len; i++) begin
                    send_item(KIND_CHAR, (i == 0) ? row : 2'($urandom_range(3)),
                              8'($urandom_range(1, 255)));
                end
                send_item(KIND_CHAR, row, CODE_END);
                sent += len + 1;
            end
        end
    endtask

    // receiver with random stalls unless in burst mode
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare every strobe transfer with the oldest expectation
    always @(posedge aclk) begin : strobe_check
        strobe_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (strobe_q.size() == 0) begin
                report_mismatch("unexpected strobe", 0, m_tdata);
            end else begin
                want = strobe_q.pop_front();
                if (m_tuser !== want.rs) report_mismatch("rs", want.rs, m_tuser);
                if (m_tdata[3:0] !== want.nibble)
                    report_mismatch("nibble", want.nibble, m_tdata[3:0]);
                if (m_tdata[21:4] !== want.wait_us)
                    report_mismatch("wait_before_us", want.wait_us, m_tdata[21:4]);
                if (m_tlast !== want.last) report_mismatch("last", want.last, m_tlast);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        mismatch_count = 0;
        burst_mode     = 1'b0;
        line_col       = 0;
        line_is_full   = 1'b0;
        wait_cfg.power_up_wait_us = 18'd132000;
        wait_cfg.wake_gap_us      = 18'd10000;
        wait_cfg.nibble_gap_us    = 18'd1000;
        wait_cfg.byte_gap_us      = 18'd2000;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_init();
        test_overlong_line();
        test_row_starts();

        set_waits(32'h0, 32'h0, 32'h0, 32'h0);
        burst_mode = 1'b1;
        send_item(KIND_INIT, 2'd0, 8'h00);
        test_random_lines(10, 1'b0);
        burst_mode = 1'b0;

        set_waits(32'hFFFF_FFFF, 32'hFFFF_FFFF, {14'h0, WAIT_MAX}, {14'h0, WAIT_MAX});
        send_item(KIND_INIT, 2'd3, 8'hFF);
        test_random_lines(20, 1'b1);

        set_waits($urandom, $urandom, $urandom, $urandom);
        send_item(KIND_INIT, 2'd1, 8'h5A);
        test_random_lines(40, 1'b1);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && strobe_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lcdw_pkg.sv
hw/rtl/lcdw_regs.sv
hw/rtl/lcdw_ctrl.sv
hw/rtl/lcdw_dp.sv
hw/rtl/char_lcd_4bit_line_writer.sv
bench/tb_char_lcd_4bit_line_writer.sv
